// File: sv/tcne_pkg.sv
// ----------------------------------------------------------------------------
// tcne_pkg
// Shared types, constants and the direction table for the terrain cell
// normal encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tcne_pkg;

	// Field widths
	localparam int HEIGHT_W = 16;
	localparam int WORD_W   = 16;
	localparam int FLAGS_W  = 16;
	localparam int VEC_W    = HEIGHT_W + 1;      // height difference
	localparam int ENT_W    = 16;                // Q14 component
	localparam int PROD_W   = VEC_W + ENT_W;     // one product
	localparam int DOT_W    = PROD_W + 2;        // sum of three terms
	localparam int TBL_AW   = 8;
	localparam int TBL_DEPTH = 256;

	localparam int TABLE_ENTRIES_DEF = 256;

	// Flag word and preservation codes
	localparam int FLAG_WET0_BIT   = 11;
	localparam int FLAG_WET1_BIT   = 12;
	localparam int FLAG_HIDDEN_BIT = 14;
	localparam logic [3:0] TYPE_LOCKED = 4'd13;
	localparam logic [3:0] TYPE_DRY_MAX = 4'd3;
	localparam logic [HEIGHT_W-1:0] MEDIA_SENTINEL = 16'h86FB;

	// Table generation constants
	localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
	localparam int Q14_ONE    = 16384;
	localparam int FULL_TURN  = 1024;
	localparam int PITCH_INIT = 'h4020;
	localparam int PITCH_STEP = 'h444;
	localparam int AZ_INIT    = 'h20;
	localparam int AZ_TURN    = 'h10000;

	typedef logic [TBL_DEPTH-1:0][3*ENT_W-1:0] tcne_table_t;

	// One classified cell, passed from the front to the back
	typedef struct packed {
		logic                     keep;
		logic [WORD_W-1:0]        old_word;
		logic signed [VEC_W-1:0]  v0x;
		logic signed [VEC_W-1:0]  v0y;
		logic signed [VEC_W-1:0]  v1x;
		logic signed [VEC_W-1:0]  v1y;
	} tcne_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tcne_qstat_t;

	// Unsigned quotient by shift and subtract, used only while building the table
	function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
		longint unsigned q, r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Signed quotient truncated toward zero, positive divisor
	function automatic int div_trunc(int num, int den);
		longint unsigned mag;
		mag = div_u64(longint'((num < 0) ? -num : num), longint'(den));
		return (num < 0) ? -int'(mag) : int'(mag);
	endfunction

	// Unsigned Q60 product
	function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
		longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
		al = a & 64'hFFFFFFFF;
		ah = a >> 32;
		bl = b & 64'hFFFFFFFF;
		bh = b >> 32;
		ll = al * bl;
		lh = al * bh;
		hl = ah * bl;
		hh = ah * bh;
		mid = (ll >> 32) + (lh & 64'hFFFFFFFF) + (hl & 64'hFFFFFFFF);
		lo = (ll & 64'hFFFFFFFF) | (mid << 32);
		hi = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
		return (hi << 4) | (lo >> 60);
	endfunction

	// Sine and cosine (Q14, rounded) of r*pi/512, packed {sin, cos}
	function automatic logic [31:0] quadrant_sc(int r);
		longint unsigned x, x2, st, ss, ct, cs, dv_s, dv_c, s, c;
		x = (PI_Q60 >> 9) * longint'(r);
		x2 = mul_q60(x, x);
		st = x;
		ss = x;
		ct = 64'd1 << 60;
		cs = ct;
		for (int n = 1; n <= 16; n++) begin
			dv_s = longint'((2 * n) * (2 * n + 1));
			dv_c = longint'((2 * n - 1) * (2 * n));
			st = div_u64(mul_q60(st, x2), dv_s);
			ct = div_u64(mul_q60(ct, x2), dv_c);
			if ((n & 1) == 1) begin
				ss = ss - st;
				cs = cs - ct;
			end else begin
				ss = ss + st;
				cs = cs + ct;
			end
		end
		s = (ss + (64'd1 << 45)) >> 46;
		c = (cs + (64'd1 << 45)) >> 46;
		return {s[15:0], c[15:0]};
	endfunction

	// Direction rings of constant pitch, entries {x, y, z}
	function automatic tcne_table_t build_table();
		int sin_t [FULL_TURN];
		int cos_t [FULL_TURN];
		tcne_table_t tbl;
		logic [31:0] sc;
		int unsigned pitch;
		int entry, p, cp, count, step, az, left, a, s, c;
		longint xv, yv;
		tbl = '0;
		for (int i = 0; i < FULL_TURN; i++) begin
			sc = quadrant_sc(i & 255);
			s = int'($signed(sc[31:16]));
			c = int'($signed(sc[15:0]));
			case (i >> 8)
				0: begin sin_t[i] = s;  cos_t[i] = c;  end
				1: begin sin_t[i] = c;  cos_t[i] = -s; end
				2: begin sin_t[i] = -s; cos_t[i] = -c; end
				default: begin sin_t[i] = -c; cos_t[i] = s; end
			endcase
		end
		sin_t[0] = 0;         cos_t[0] = Q14_ONE;
		sin_t[256] = Q14_ONE; cos_t[256] = 0;
		sin_t[512] = 0;       cos_t[512] = -Q14_ONE;
		sin_t[768] = -Q14_ONE; cos_t[768] = 0;
		entry = 0;
		pitch = PITCH_INIT;
		while (entry < TBL_DEPTH) begin
			p = int'((pitch >> 6) & 32'h3FF);
			cp = cos_t[p];
			count = div_trunc(cp * 4, PITCH_STEP) + 1;
			if (count > 0) begin
				step = int'(div_u64(longint'(AZ_TURN), longint'(count)));
				az = AZ_INIT;
				left = count;
				while (left > 0 && entry < TBL_DEPTH) begin
					a = (az >>> 6) & 'h3FF;
					xv = longint'(cos_t[a]) * longint'(cp);
					yv = longint'(sin_t[a]) * longint'(cp);
					xv = xv >>> 14;
					yv = yv >>> 14;
					tbl[entry] = {xv[15:0], yv[15:0], 16'(sin_t[p])};
					entry = entry + 1;
					az = az + step;
					left = left - 1;
				end
			end
			pitch = pitch - PITCH_STEP;
		end
		return tbl;
	endfunction

	localparam tcne_table_t DIR_TABLE = build_table();

endpackage

`default_nettype wire

// File: sv/tcne_cell_if.sv
// ----------------------------------------------------------------------------
// tcne_cell_if
// Input channel: one terrain cell per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcne_cell_if;
	logic        valid;
	logic        ready;
	logic [15:0] height_a;
	logic [15:0] height_b;
	logic [15:0] height_c;
	logic [15:0] height_d;
	logic        cell_parity;
	logic        corners_changed;
	logic [15:0] cell_flags;
	logic [15:0] liquid_height;
	logic [15:0] old_normal_word;

	modport source (output valid, height_a, height_b, height_c, height_d, cell_parity,
		corners_changed, cell_flags, liquid_height, old_normal_word, input ready);
	modport sink (input valid, height_a, height_b, height_c, height_d, cell_parity,
		corners_changed, cell_flags, liquid_height, old_normal_word, output ready);
endinterface

`default_nettype wire

// File: sv/tcne_result_if.sv
// ----------------------------------------------------------------------------
// tcne_result_if
// Output channel: one encoded normal word per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcne_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] normal_word;
	logic        word_changed;
	logic        word_preserved;

	modport source (output valid, normal_word, word_changed, word_preserved, input ready);
	modport sink (input valid, normal_word, word_changed, word_preserved, output ready);
endinterface

`default_nettype wire

// File: sv/tcne_front.sv
// ----------------------------------------------------------------------------
// tcne_front
// Accept cells, apply the preservation rules and reduce both triangle
// normals to small search vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module tcne_front (
	tcne_cell_if.sink            tile,
	input  tcne_pkg::tcne_qstat_t qstat,
	output logic                 push,
	output tcne_pkg::tcne_job_t  job
);
	import tcne_pkg::*;

	logic signed [VEC_W-1:0] ha, hb, hc, hd;
	logic [3:0] t0, t1;
	logic rule_keep;

	// Accept whenever the queue has room
	assign tile.ready = !qstat.full;
	assign push = tile.valid && !qstat.full;

	assign ha = VEC_W'($signed(tile.height_a));
	assign hb = VEC_W'($signed(tile.height_b));
	assign hc = VEC_W'($signed(tile.height_c));
	assign hd = VEC_W'($signed(tile.height_d));
	assign t0 = tile.cell_flags[7:4];
	assign t1 = tile.cell_flags[3:0];

	// Preservation rules
	always_comb begin
		rule_keep = 1'b0;
		if (tile.old_normal_word == '0) rule_keep = 1'b1;
		if (tile.cell_flags[FLAG_HIDDEN_BIT]) rule_keep = 1'b1;
		if (t0 == TYPE_LOCKED || t1 == TYPE_LOCKED) rule_keep = 1'b1;
		if (tile.liquid_height == MEDIA_SENTINEL) rule_keep = 1'b1;
		if ((t0 <= TYPE_DRY_MAX && !tile.cell_flags[FLAG_WET0_BIT]) ||
			(t1 <= TYPE_DRY_MAX && !tile.cell_flags[FLAG_WET1_BIT])) rule_keep = 1'b1;
	end

	// Runtime normals divided by 512; the vertical term is always 512
	always_comb begin
		job.keep = !tile.corners_changed || rule_keep;
		job.old_word = tile.old_normal_word;
		if (!tile.cell_parity) begin
			job.v0x = hd - hc;
			job.v0y = ha - hd;
			job.v1x = ha - hb;
			job.v1y = hb - hc;
		end else begin
			job.v0x = ha - hb;
			job.v0y = ha - hd;
			job.v1x = hd - hc;
			job.v1y = hb - hc;
		end
	end

endmodule

`default_nettype wire

// File: sv/tcne_queue.sv
// ----------------------------------------------------------------------------
// tcne_queue
// Two-entry queue of classified cells between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tcne_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tcne_pkg::tcne_job_t   push_job,
	input  logic                  pop,
	output tcne_pkg::tcne_job_t   head,
	output tcne_pkg::tcne_qstat_t qstat
);
	import tcne_pkg::*;

	tcne_job_t slot_q [2];
	logic      wr_q, rd_q;
	logic [1:0] cnt_q;

	assign head = slot_q[rd_q];
	assign qstat.full = cnt_q == 2'd2;
	assign qstat.empty = cnt_q == 2'd0;

	// Store item
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/tcne_back.sv
// ----------------------------------------------------------------------------
// tcne_back
// Search the direction table for both triangles, one entry per cycle, and
// hold the result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tcne_back #(
	parameter int TABLE_ENTRIES = tcne_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcne_pkg::tcne_job_t   head,
	input  tcne_pkg::tcne_qstat_t qstat,
	output logic                  pop,
	tcne_result_if.source         result
);
	import tcne_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic busy_q, issue_q;
	logic [IDX_W-1:0] idx_q;
	logic signed [VEC_W-1:0] v0x_q, v0y_q, v1x_q, v1y_q;
	logic [WORD_W-1:0] old_q;

	logic [3*ENT_W-1:0] ent_s1;
	logic v_s1, first_s1, last_s1;
	logic [IDX_W-1:0] idx_s1;

	logic signed [PROD_W-1:0] p0x_s2, p0y_s2, p1x_s2, p1y_s2;
	logic signed [ENT_W-1:0] z_s2;
	logic v_s2, first_s2, last_s2;
	logic [IDX_W-1:0] idx_s2;

	logic signed [DOT_W-1:0] best0_q, best1_q, d0, d1, zt;
	logic [IDX_W-1:0] bidx0_q, bidx1_q, nidx0, nidx1;
	logic take0, take1;

	logic out_valid_q, out_preserved_q, out_changed_q;
	logic [WORD_W-1:0] out_word_q;
	logic [WORD_W-1:0] new_word;

	assign pop = !busy_q && !qstat.empty && (!out_valid_q || result.ready);

	// Hold the job and step the table index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			issue_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (pop && !head.keep) begin
				busy_q <= 1'b1;
				issue_q <= 1'b1;
				idx_q <= '0;
			end else begin
				if (issue_q) begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) issue_q <= 1'b0;
				end
				if (v_s2 && last_s2) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			v0x_q <= head.v0x;
			v0y_q <= head.v0y;
			v1x_q <= head.v1x;
			v1y_q <= head.v1y;
			old_q <= head.old_word;
		end
	end

	// Stage 1: table read; stage 2: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue_q;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ent_s1 <= DIR_TABLE[TBL_AW'(idx_q)];
		first_s1 <= idx_q == '0;
		last_s1 <= idx_q == LAST_IDX;
		idx_s1 <= idx_q;
		p0x_s2 <= v0x_q * $signed(ent_s1[3*ENT_W-1:2*ENT_W]);
		p0y_s2 <= v0y_q * $signed(ent_s1[2*ENT_W-1:ENT_W]);
		p1x_s2 <= v1x_q * $signed(ent_s1[3*ENT_W-1:2*ENT_W]);
		p1y_s2 <= v1y_q * $signed(ent_s1[2*ENT_W-1:ENT_W]);
		z_s2 <= $signed(ent_s1[ENT_W-1:0]);
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		idx_s2 <= idx_s1;
	end

	// Stage 3: sum and keep the first maximum
	always_comb begin
		zt = DOT_W'(z_s2) <<< 9;
		d0 = DOT_W'(p0x_s2) + DOT_W'(p0y_s2) + zt;
		d1 = DOT_W'(p1x_s2) + DOT_W'(p1y_s2) + zt;
		take0 = first_s2 || d0 > best0_q;
		take1 = first_s2 || d1 > best1_q;
		nidx0 = take0 ? idx_s2 : bidx0_q;
		nidx1 = take1 ? idx_s2 : bidx1_q;
		new_word = {8'(nidx0), 8'(nidx1)};
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (take0) best0_q <= d0;
			if (take1) best1_q <= d1;
			bidx0_q <= nidx0;
			bidx1_q <= nidx1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((pop && head.keep) || (v_s2 && last_s2)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.keep) begin
			out_word_q <= head.old_word;
			out_changed_q <= 1'b0;
			out_preserved_q <= 1'b1;
		end else if (v_s2 && last_s2) begin
			out_word_q <= new_word;
			out_changed_q <= new_word != old_q;
			out_preserved_q <= 1'b0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.normal_word = out_word_q;
	assign result.word_changed = out_changed_q;
	assign result.word_preserved = out_preserved_q;

endmodule

`default_nettype wire

// File: sv/terrain_cell_normal_encoder.sv
// ----------------------------------------------------------------------------
// terrain_cell_normal_encoder
// Quantize the two triangle normals of a terrain cell to direction table
// indices and pack them into one word.
// ----------------------------------------------------------------------------
// A cell that is kept by a preservation rule or has unchanged corners offers
// its old word as soon as it leaves the queue, without a table search. Any
// other cell leaves the queue only when the back end is idle; then both
// normals are scored against one table entry per cycle through a three-stage
// read/multiply/compare pipeline, so the table search sets the rate. A two-item
// queue lets new cells be accepted while a search runs and while a result
// waits to be taken.
`default_nettype none

module terrain_cell_normal_encoder #(
	parameter int TABLE_ENTRIES = tcne_pkg::TABLE_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tcne_cell_if.sink     tile,
	tcne_result_if.source result
);
	import tcne_pkg::*;

	tcne_job_t   push_job, head;
	tcne_qstat_t qstat;
	logic        push, pop;

	tcne_front u_front (
		.tile  (tile),
		.qstat (qstat),
		.push  (push),
		.job   (push_job)
	);

	tcne_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	tcne_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

	// Never take an item from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("pop from empty queue");

	// Never store into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full) else $error("push into full queue");

	// A kept word cannot differ from the old word
	a_kept_same: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.word_preserved) |-> !result.word_changed)
		else $error("kept word flagged as changed");

endmodule

`default_nettype wire

// File: tb/terrain_cell_normal_encoder_tb.sv
// ----------------------------------------------------------------------------
// terrain_cell_normal_encoder_tb
// Self-checking regression for the terrain cell normal encoder: directed
// corner cases, back-pressure phases and a long random run. Each result is
// checked against a behavioral model of the normal quantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module terrain_cell_normal_encoder_tb;
	import tcne_pkg::*;

	typedef struct {
		logic [15:0] ha, hb, hc, hd;
		logic        parity;
		logic        changed;
		logic [15:0] flags;
		logic [15:0] media;
		logic [15:0] old_word;
	} cell_t;

	typedef struct {
		logic [15:0] word;
		logic        changed;
		logic        preserved;
	} word_t;

	typedef longint vec3_t [3];

	logic clk;
	logic arst_n;

	tcne_cell_if   cell_ch ();
	tcne_result_if res_ch ();

	terrain_cell_normal_encoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tile   (cell_ch),
		.result (res_ch)
	);

	// Direction table built here from the ring description
	int dir_x [256];
	int dir_y [256];
	int dir_z [256];

	word_t expected_words [$];
	int    error_count;
	int    words_checked;
	int    words_kept;
	int    hold_cycles;
	bit    no_idle;

	// Clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int round_q14(real v);
		real s;
		s = 16384.0 * v;
		if (s >= 0.0)
			return $rtoi(s + 0.5);
		return -$rtoi(-s + 0.5);
	endfunction

	function automatic longint floor14(longint v);
		if (v >= 0)
			return v >>> 14;
		return -(((-v) + 16383) >>> 14);
	endfunction

	task automatic make_directions();
		int          sn [1024];
		int          cs [1024];
		int unsigned pitch_acc;
		int          entry, p, cp, count, step, az_acc, left, a;
		real         ang;
		for (int i = 0; i < 1024; i++) begin
			ang = 2.0 * 3.14159265358979323846 * i / 1024.0;
			sn[i] = round_q14($sin(ang));
			cs[i] = round_q14($cos(ang));
		end
		sn[0] = 0;       cs[0] = 16384;
		sn[256] = 16384; cs[256] = 0;
		sn[512] = 0;     cs[512] = -16384;
		sn[768] = -16384; cs[768] = 0;
		entry = 0;
		pitch_acc = 32'h4020;
		while (entry < 256) begin
			p = int'((pitch_acc >> 6) & 32'h3FF);
			cp = cs[p];
			count = (cp * 4) / 'h444 + 1;
			if (count > 0) begin
				step = 'h10000 / count;
				az_acc = 'h20;
				left = count;
				while (left > 0 && entry < 256) begin
					a = int'((unsigned'(az_acc) >> 6) & 32'h3FF);
					dir_x[entry] = int'(floor14(longint'(cs[a]) * cp));
					dir_y[entry] = int'(floor14(longint'(sn[a]) * cp));
					dir_z[entry] = sn[p];
					entry++;
					az_acc += step;
					left--;
				end
			end
			pitch_acc -= 32'h444;
		end
	endtask

	function automatic bit keep_rule(cell_t c);
		logic [3:0] t0, t1;
		t0 = c.flags[7:4];
		t1 = c.flags[3:0];
		if (c.old_word == 16'h0) return 1'b1;
		if (c.flags[FLAG_HIDDEN_BIT]) return 1'b1;
		if (t0 == TYPE_LOCKED || t1 == TYPE_LOCKED) return 1'b1;
		if (c.media == MEDIA_SENTINEL) return 1'b1;
		if ((t0 <= TYPE_DRY_MAX && !c.flags[FLAG_WET0_BIT]) ||
			(t1 <= TYPE_DRY_MAX && !c.flags[FLAG_WET1_BIT])) return 1'b1;
		return 1'b0;
	endfunction

	function automatic void facet_normal(vec3_t p, vec3_t q, vec3_t r, output vec3_t n);
		longint ax, ay, az, bx, by, bz;
		ax = q[0] - p[0]; ay = q[1] - p[1]; az = q[2] - p[2];
		bx = r[0] - p[0]; by = r[1] - p[1]; bz = r[2] - p[2];
		n[0] = ay * bz - az * by;
		n[1] = az * bx - ax * bz;
		n[2] = ax * by - ay * bx;
	endfunction

	// Pick the best-aligned direction; the lowest index wins a tie
	function automatic logic [7:0] closest_direction(vec3_t n);
		longint d, best_dot;
		int     best;
		best = 0;
		best_dot = 0;
		for (int i = 0; i < 256; i++) begin
			d = -n[0] * dir_x[i] + n[2] * dir_y[i] + n[1] * dir_z[i];
			if (i == 0 || d > best_dot) begin
				best_dot = d;
				best = i;
			end
		end
		return best[7:0];
	endfunction

	function automatic word_t encode_cell(cell_t c);
		word_t w;
		vec3_t pa, pb, pc, pd, n0, n1;
		pa = '{0, longint'($signed(c.ha)), 0};
		pb = '{-512, longint'($signed(c.hb)), 0};
		pc = '{-512, longint'($signed(c.hc)), 512};
		pd = '{0, longint'($signed(c.hd)), 512};
		w.word = c.old_word;
		w.preserved = 1'b1;
		if (c.changed && !keep_rule(c)) begin
			if (!c.parity) begin
				facet_normal(pa, pc, pd, n0);
				facet_normal(pa, pb, pc, n1);
			end else begin
				facet_normal(pa, pb, pd, n0);
				facet_normal(pb, pc, pd, n1);
			end
			w.word = {closest_direction(n0), closest_direction(n1)};
			w.preserved = 1'b0;
		end
		w.changed = (w.word != c.old_word);
		return w;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// Send one cell; valid stays high into the next item when there is no gap
	task automatic send_cell(cell_t c);
		int gap;
		gap = no_idle ? 0 : $urandom_range(14);
		if (gap > 0) begin
			cell_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_ch.height_a        <= c.ha;
		cell_ch.height_b        <= c.hb;
		cell_ch.height_c        <= c.hc;
		cell_ch.height_d        <= c.hd;
		cell_ch.cell_parity     <= c.parity;
		cell_ch.corners_changed <= c.changed;
		cell_ch.cell_flags      <= c.flags;
		cell_ch.liquid_height   <= c.media;
		cell_ch.old_normal_word <= c.old_word;
		cell_ch.valid           <= 1'b1;
		do @(posedge clk); while (!cell_ch.ready);
		expected_words.insert(expected_words.size(), encode_cell(c));
	endtask

	task automatic go_quiet();
		cell_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		go_quiet();
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// A cell that passes every preservation rule, with random content
	function automatic cell_t random_live_cell(bit wide);
		cell_t c;
		int    span;
		span = wide ? 65535 : $urandom_range(4000);
		c.ha = wide ? 16'($urandom) : 16'($urandom_range(span) - span / 2);
		c.hb = wide ? 16'($urandom) : 16'($urandom_range(span) - span / 2);
		c.hc = wide ? 16'($urandom) : 16'($urandom_range(span) - span / 2);
		c.hd = wide ? 16'($urandom) : 16'($urandom_range(span) - span / 2);
		c.parity = 1'($urandom);
		c.changed = 1'b1;
		c.flags = 16'($urandom);
		c.flags[FLAG_HIDDEN_BIT] = 1'b0;
		c.flags[7:4] = 4'($urandom_range(4, 12));
		c.flags[3:0] = 4'($urandom_range(15));
		if (c.flags[3:0] == TYPE_LOCKED)
			c.flags[3:0] = 4'd14;
		if (c.flags[3:0] <= TYPE_DRY_MAX)
			c.flags[FLAG_WET1_BIT] = 1'b1;
		if ($urandom_range(3) == 0) begin
			c.flags[7:4] = 4'($urandom_range(3));
			c.flags[FLAG_WET0_BIT] = 1'b1;
		end
		c.media = 16'($urandom);
		if (c.media == MEDIA_SENTINEL)
			c.media = 16'h0;
		c.old_word = 16'($urandom_range(1, 65535));
		return c;
	endfunction

	function automatic cell_t random_noise_cell();
		cell_t c;
		c.ha = 16'($urandom); c.hb = 16'($urandom);
		c.hc = 16'($urandom); c.hd = 16'($urandom);
		c.parity = 1'($urandom);
		c.changed = 1'($urandom);
		c.flags = 16'($urandom);
		c.media = ($urandom_range(7) == 0) ? MEDIA_SENTINEL : 16'($urandom);
		c.old_word = ($urandom_range(7) == 0) ? 16'h0 : 16'($urandom);
		return c;
	endfunction

	// Extremes, each preservation rule, both splits
	task automatic test_directed();
		cell_t base, c;
		base = random_live_cell(1'b0);
		base.flags = 16'h0055;
		base.media = 16'h0000;
		base.old_word = 16'h1234;
		c = base; c.ha = 16'h0; c.hb = 16'h0; c.hc = 16'h0; c.hd = 16'h0;     // flat
		send_cell(c); c.parity = 1'b1; send_cell(c);
		c = base; c.ha = 16'h7FFF; c.hb = 16'h8000; c.hc = 16'h7FFF; c.hd = 16'h8000;
		c.parity = 1'b0; send_cell(c); c.parity = 1'b1; send_cell(c);
		c = base; c.ha = 16'h8000; c.hb = 16'h7FFF; c.hc = 16'h8000; c.hd = 16'h7FFF;
		c.parity = 1'b0; send_cell(c); c.parity = 1'b1; send_cell(c);
		c = base; c.ha = 16'h7FFF; c.hb = 16'h7FFF; c.hc = 16'h8000; c.hd = 16'h8000;
		send_cell(c); c.parity = 1'b0; send_cell(c);
		c = base; c.ha = 16'h0200; c.hb = 16'h0000; c.hc = 16'h0000; c.hd = 16'h0200;
		send_cell(c);
		c = base; c.changed = 1'b0; send_cell(c);                              // unchanged
		c = base; c.old_word = 16'h0; send_cell(c);                            // old word zero
		c = base; c.flags[FLAG_HIDDEN_BIT] = 1'b1; send_cell(c);              // not rendered
		c = base; c.flags[7:4] = TYPE_LOCKED; send_cell(c);
		c = base; c.flags[3:0] = TYPE_LOCKED; send_cell(c);
		c = base; c.media = MEDIA_SENTINEL; send_cell(c);
		c = base; c.flags[7:4] = 4'd3; send_cell(c);                           // dry first
		c.flags[FLAG_WET0_BIT] = 1'b1; send_cell(c);
		c = base; c.flags[3:0] = 4'd0; send_cell(c);                           // dry second
		c.flags[FLAG_WET1_BIT] = 1'b1; send_cell(c);
		c = base; c.flags = 16'hBFFF; c.flags[7:0] = 8'hFF; c.old_word = 16'hFFFF;
		send_cell(c);
		c = base; c.flags = 16'h0044; c.media = 16'h7FFF; c.old_word = 16'h0001;
		send_cell(c);
		c = base; c.media = 16'h8000; send_cell(c);
		drain();
	endtask

	// Stall the result side for a long stretch while cells keep coming
	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_cycles = 700;
		@(posedge clk);
		for (int i = 0; i < 8; i++)
			send_cell(($urandom_range(1) == 0) ? random_live_cell(1'b0) : random_noise_cell());
		no_idle = 1'b0;
		drain();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			no_idle = (i % 100) < 20;
			if ($urandom_range(9) < 7)
				send_cell(random_live_cell($urandom_range(3) == 0));
			else
				send_cell(random_noise_cell());
			if (i == count / 2)
				drain();
		end
		no_idle = 1'b0;
	endtask

	// Result side: random stalls, check each item against the oldest expectation
	initial begin
		word_t want;
		int    stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = no_idle ? 0 : $urandom_range(14);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid || !res_ch.ready);
			if (expected_words.size() == 0) begin
				$display("[%0t] unexpected item, word %h", $realtime, res_ch.normal_word);
				error_count++;
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (want.preserved) words_kept++;
				if (res_ch.normal_word !== want.word)
					report_mismatch("normal_word", res_ch.normal_word, want.word);
				if (res_ch.word_changed !== want.changed)
					report_mismatch("word_changed", 16'(res_ch.word_changed),
						16'(want.changed));
				if (res_ch.word_preserved !== want.preserved)
					report_mismatch("word_preserved", 16'(res_ch.word_preserved),
						16'(want.preserved));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((cell_ch.valid && cell_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= 5000) begin
				$display("watchdog expired with %0d items outstanding", expected_words.size());
				$display("terrain_cell_normal_encoder regression: fail");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin
		error_count = 0;
		words_checked = 0;
		words_kept = 0;
		hold_cycles = 0;
		no_idle = 1'b0;
		cell_ch.valid = 1'b0;
		cell_ch.height_a = '0;
		cell_ch.height_b = '0;
		cell_ch.height_c = '0;
		cell_ch.height_d = '0;
		cell_ch.cell_parity = 1'b0;
		cell_ch.corners_changed = 1'b0;
		cell_ch.cell_flags = '0;
		cell_ch.liquid_height = '0;
		cell_ch.old_normal_word = '0;
		arst_n = 1'b0;
		make_directions();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random(420);
		drain();
		repeat (300) @(posedge clk);

		$display("checked %0d encoded words (%0d kept by a rule or unchanged corners)",
			words_checked, words_kept);
		$display("covered both splits, every keep rule, height extremes and a long stall");
		if (error_count == 0 && expected_words.size() == 0)
			$display("terrain_cell_normal_encoder regression: pass");
		else
			$display("terrain_cell_normal_encoder regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
sv/tcne_pkg.sv
sv/tcne_cell_if.sv
sv/tcne_result_if.sv
sv/tcne_front.sv
sv/tcne_queue.sv
sv/tcne_back.sv
sv/terrain_cell_normal_encoder.sv
tb/terrain_cell_normal_encoder_tb.sv
